[src/mbet_pkg.sv]
// Shared types, constants and width helpers for the escape-time pixel block.
package mbet_pkg;

    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS_DEF = 34;

    localparam int SIZE_BITS  = 12;
    localparam int OFF_BITS   = 32;
    localparam int SCALE_BITS = 40;
    localparam int ITER_BITS  = 16;
    localparam int OFF_FRAC   = 12;
    localparam int SCALE_FRAC = 40;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 40;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_IMAGE_WIDTH    = 3'd0;
    localparam t_cfg_idx REG_IMAGE_HEIGHT   = 3'd1;
    localparam t_cfg_idx REG_X_OFFSET       = 3'd2;
    localparam t_cfg_idx REG_Y_OFFSET       = 3'd3;
    localparam t_cfg_idx REG_PIXEL_SCALE    = 3'd4;
    localparam t_cfg_idx REG_MAX_ITERATIONS = 3'd5;

    localparam logic [SIZE_BITS-1:0]  RST_IMAGE_WIDTH    = 12'd640;
    localparam logic [SIZE_BITS-1:0]  RST_IMAGE_HEIGHT   = 12'd480;
    localparam logic [OFF_BITS-1:0]   RST_OFFSET         = 32'd0;
    localparam logic [SCALE_BITS-1:0] RST_PIXEL_SCALE    = 40'd5497558139;
    localparam logic [ITER_BITS-1:0]  RST_MAX_ITERATIONS = 16'd255;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic [ITER_BITS-1:0]  remaining_budget;
    } t_pix_out;

    typedef struct packed {
        logic [SIZE_BITS-1:0]        image_width;
        logic [SIZE_BITS-1:0]        image_height;
        logic signed [OFF_BITS-1:0]  x_offset;
        logic signed [OFF_BITS-1:0]  y_offset;
        logic [SCALE_BITS-1:0]       pixel_scale;
        logic [ITER_BITS-1:0]        max_iterations;
    } t_cfg;

    // Which rescale the multiplier applies to its product
    typedef enum logic [1:0] {
        SEL_MAP = 2'd0,
        SEL_SQ  = 2'd1,
        SEL_DBL = 2'd2
    } t_shsel;

    typedef struct packed {
        logic   start;
        t_shsel sel;
    } t_mul_req;

    // Width of a z / c value: sign plus 5 integer bits plus fraction
    function automatic int qz_w(input int frac);
        return frac + 6;
    endfunction

    // Operand width of the shared multiplier: holds z values and the scale
    function automatic int op_w(input int frac);
        return (frac + 6 > SCALE_BITS + 1) ? frac + 6 : SCALE_BITS + 1;
    endfunction

endpackage

[src/mbet_cfg.sv]
// Configuration register file for the escape-time pixel block.
module mbet_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mbet_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [mbet_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output mbet_pkg::t_cfg                      o_cfg
);

    mbet_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width    <= mbet_pkg::RST_IMAGE_WIDTH;
            r_cfg.image_height   <= mbet_pkg::RST_IMAGE_HEIGHT;
            r_cfg.x_offset       <= $signed(mbet_pkg::RST_OFFSET);
            r_cfg.y_offset       <= $signed(mbet_pkg::RST_OFFSET);
            r_cfg.pixel_scale    <= mbet_pkg::RST_PIXEL_SCALE;
            r_cfg.max_iterations <= mbet_pkg::RST_MAX_ITERATIONS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                mbet_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data[mbet_pkg::SIZE_BITS-1:0];
                end
                mbet_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data[mbet_pkg::SIZE_BITS-1:0];
                end
                mbet_pkg::REG_X_OFFSET: begin
                    r_cfg.x_offset <= $signed(i_cfg_data[mbet_pkg::OFF_BITS-1:0]);
                end
                mbet_pkg::REG_Y_OFFSET: begin
                    r_cfg.y_offset <= $signed(i_cfg_data[mbet_pkg::OFF_BITS-1:0]);
                end
                mbet_pkg::REG_PIXEL_SCALE: begin
                    r_cfg.pixel_scale <= i_cfg_data[mbet_pkg::SCALE_BITS-1:0];
                end
                mbet_pkg::REG_MAX_ITERATIONS: begin
                    r_cfg.max_iterations <= i_cfg_data[mbet_pkg::ITER_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[src/mbet_mul.sv]
// Shared signed fixed-point multiplier: two half-width passes, rescale, saturate.
module mbet_mul #(
    parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  mbet_pkg::t_mul_req                             i_req,
    input  logic signed [mbet_pkg::op_w(FRAC_BITS)-1:0]    i_a,
    input  logic signed [mbet_pkg::op_w(FRAC_BITS)-1:0]    i_b,
    output logic                                           o_done,
    output logic signed [mbet_pkg::qz_w(FRAC_BITS)-1:0]    o_res
);

    localparam int QW = mbet_pkg::qz_w(FRAC_BITS);
    localparam int SW = mbet_pkg::op_w(FRAC_BITS);
    localparam int CW = (SW + 1) / 2;
    localparam int HW = SW - CW;
    localparam int PW = 2 * SW;
    localparam int EW = PW + 8;

    localparam int SH_MAP = mbet_pkg::OFF_FRAC + mbet_pkg::SCALE_FRAC - FRAC_BITS;
    localparam int SH_SQ  = FRAC_BITS;
    localparam int SH_DBL = FRAC_BITS - 1;

    localparam logic [EW-1:0] LIM_NEG = EW'(1) << (QW - 1);
    localparam logic [EW-1:0] LIM_POS = LIM_NEG - EW'(1);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HI   = 4'b0010,
        PH_LO   = 4'b0100,
        PH_POST = 4'b1000
    } t_mphase;

    t_mphase          r_phase, n_phase;
    logic [SW-1:0]    r_ma;
    logic [SW-1:0]    r_mb;
    logic             r_neg;
    mbet_pkg::t_shsel r_sel;
    logic [PW-1:0]    r_acc;
    logic             r_done;
    logic signed [QW-1:0] r_res;

    logic [SW-1:0]    a_mag;
    logic [SW-1:0]    b_mag;
    logic [CW-1:0]    mb_part;
    logic [SW+CW-1:0] prod_part;
    logic [EW-1:0]    ext_acc;
    logic [EW-1:0]    scaled;
    logic [EW-1:0]    limit;
    logic [QW-1:0]    mag;

    function automatic logic [EW-1:0] rescale(input logic [EW-1:0] e, input int sh);
        logic [EW-1:0] r;
        if (sh >= 0) begin
            r = e >> sh;
        end else begin
            r = e << (-sh);
        end
        return r;
    endfunction

    assign a_mag = i_a[SW-1] ? $unsigned(-i_a) : $unsigned(i_a);
    assign b_mag = i_b[SW-1] ? $unsigned(-i_b) : $unsigned(i_b);

    // Operand A full width times one half of operand B per cycle, upper half first
    assign mb_part   = (r_phase == PH_HI) ? CW'(r_mb[SW-1:CW]) : r_mb[CW-1:0];
    assign prod_part = {{CW{1'b0}}, r_ma} * {{SW{1'b0}}, mb_part};

    assign ext_acc = EW'(r_acc);

    always_comb begin
        case (r_sel)
            mbet_pkg::SEL_MAP: scaled = rescale(ext_acc, SH_MAP);
            mbet_pkg::SEL_SQ:  scaled = rescale(ext_acc, SH_SQ);
            mbet_pkg::SEL_DBL: scaled = rescale(ext_acc, SH_DBL);
            default:           scaled = rescale(ext_acc, SH_SQ);
        endcase
    end

    // Magnitude truncated toward zero, clamped to the signed range
    assign limit = r_neg ? LIM_NEG : LIM_POS;
    assign mag   = (scaled > limit) ? limit[QW-1:0] : scaled[QW-1:0];

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: if (i_req.start) n_phase = PH_HI;
            PH_HI:   n_phase = PH_LO;
            PH_LO:   n_phase = PH_POST;
            PH_POST: n_phase = PH_IDLE;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == PH_POST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_req.start) begin
            r_ma  <= a_mag;
            r_mb  <= b_mag;
            r_neg <= i_a[SW-1] ^ i_b[SW-1];
            r_sel <= i_req.sel;
        end
        if (r_phase == PH_HI) begin
            r_acc <= PW'(prod_part);
        end
        if (r_phase == PH_LO) begin
            r_acc <= (r_acc << CW) + PW'(prod_part);
        end
        if (r_phase == PH_POST) begin
            r_res <= r_neg ? -$signed(mag) : $signed(mag);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[src/mbet_seq.sv]
// Pixel sequencer: coordinate mapping, z iteration, escape test and budget count.
module mbet_seq #(
    parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  mbet_pkg::t_cfg                                 i_cfg,
    input  logic                                           i_in_valid,
    input  mbet_pkg::t_pix_in                              i_pix,
    output logic                                           o_in_stall,
    output logic                                           o_res_valid,
    output mbet_pkg::t_pix_out                             o_res,
    input  logic                                           i_res_take,
    output mbet_pkg::t_mul_req                             o_mul_req,
    output logic signed [mbet_pkg::op_w(FRAC_BITS)-1:0]    o_mul_a,
    output logic signed [mbet_pkg::op_w(FRAC_BITS)-1:0]    o_mul_b,
    input  logic                                           i_mul_done,
    input  logic signed [mbet_pkg::qz_w(FRAC_BITS)-1:0]    i_mul_res
);

    localparam int QW  = mbet_pkg::qz_w(FRAC_BITS);
    localparam int SW  = mbet_pkg::op_w(FRAC_BITS);
    localparam int CB  = mbet_pkg::COORD_BITS;
    localparam int IB  = mbet_pkg::ITER_BITS;
    localparam int SZW = (CB > mbet_pkg::SIZE_BITS) ? CB : mbet_pkg::SIZE_BITS;
    localparam int PBW = (CB + 14 > mbet_pkg::OFF_BITS + 2) ? CB + 14
                                                            : mbet_pkg::OFF_BITS + 2;

    localparam logic [SZW-1:0] COORD_MASK = SZW'((64'd1 << CB) - 64'd1);
    localparam logic signed [QW+1:0] QZ_MAX =
        $signed((QW+2)'((64'd1 << (QW - 1)) - 64'd1));
    localparam logic signed [QW+1:0] QZ_MIN = -QZ_MAX - (QW+2)'(1);
    localparam logic signed [QW:0] FOUR = $signed((QW+1)'(64'd4 << FRAC_BITS));

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MAPX = 9'b000000010,
        S_MAPY = 9'b000000100,
        S_SQX  = 9'b000001000,
        S_SQY  = 9'b000010000,
        S_CHK  = 9'b000100000,
        S_DBL  = 9'b001000000,
        S_UPD  = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_issued;
    logic [CB-1:0]        r_px;
    logic [CB-1:0]        r_py;
    logic [IB-1:0]        r_left;
    logic signed [QW-1:0] r_cx;
    logic signed [QW-1:0] r_cy;
    logic signed [QW-1:0] r_zx;
    logic signed [QW-1:0] r_zy;
    logic signed [QW-1:0] r_xx;
    logic signed [QW-1:0] r_yy;

    logic                  in_mul_state;
    logic [CB-1:0]         coord_sel;
    logic [SZW-1:0]        size_m;
    logic signed [31:0]    off_sel;
    logic [PBW-1:0]        p_pos;
    logic signed [QW:0]    mag_sum;
    logic                  escape;
    logic signed [QW+1:0]  upd_x;
    logic signed [QW+1:0]  upd_y;

    function automatic logic signed [QW-1:0] sat_qz(input logic signed [QW+1:0] v);
        logic signed [QW+1:0] r;
        if (v > QZ_MAX) begin
            r = QZ_MAX;
        end else if (v < QZ_MIN) begin
            r = QZ_MIN;
        end else begin
            r = v;
        end
        return $signed(r[QW-1:0]);
    endfunction

    assign in_mul_state = (r_state == S_MAPX) || (r_state == S_MAPY) ||
                          (r_state == S_SQX)  || (r_state == S_SQY)  ||
                          (r_state == S_DBL);

    // Pixel position in Q.12: (coord << 12) - (size << 11) + offset
    assign coord_sel = (r_state == S_MAPX) ? r_px : r_py;
    assign size_m    = ((r_state == S_MAPX) ? SZW'(i_cfg.image_width)
                                            : SZW'(i_cfg.image_height)) & COORD_MASK;
    assign off_sel   = (r_state == S_MAPX) ? i_cfg.x_offset : i_cfg.y_offset;
    assign p_pos     = (PBW'(coord_sel) << mbet_pkg::OFF_FRAC)
                     - (PBW'(size_m) << (mbet_pkg::OFF_FRAC - 1))
                     + PBW'(off_sel);

    always_comb begin
        o_mul_req.start = in_mul_state && !r_issued;
        case (r_state)
            S_MAPX, S_MAPY: begin
                o_mul_req.sel = mbet_pkg::SEL_MAP;
                o_mul_a       = SW'($signed(p_pos));
                o_mul_b       = $signed(SW'(i_cfg.pixel_scale));
            end
            S_SQX: begin
                o_mul_req.sel = mbet_pkg::SEL_SQ;
                o_mul_a       = SW'(r_zx);
                o_mul_b       = SW'(r_zx);
            end
            S_SQY: begin
                o_mul_req.sel = mbet_pkg::SEL_SQ;
                o_mul_a       = SW'(r_zy);
                o_mul_b       = SW'(r_zy);
            end
            default: begin
                o_mul_req.sel = mbet_pkg::SEL_DBL;
                o_mul_a       = SW'(r_zx);
                o_mul_b       = SW'(r_zy);
            end
        endcase
    end

    assign mag_sum = (QW+1)'(r_xx) + (QW+1)'(r_yy);
    assign escape  = (mag_sum >= FOUR);

    // i_mul_res still holds 2*zx*zy during the update cycle
    assign upd_x = (QW+2)'(r_xx) - (QW+2)'(r_yy) + (QW+2)'(r_cx);
    assign upd_y = (QW+2)'(i_mul_res) + (QW+2)'(r_cy);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_MAPX;
            S_MAPX: if (i_mul_done) n_state = S_MAPY;
            S_MAPY: begin
                if (i_mul_done) n_state = (r_left == '0) ? S_OUT : S_SQX;
            end
            S_SQX:  if (i_mul_done) n_state = S_SQY;
            S_SQY:  if (i_mul_done) n_state = S_CHK;
            S_CHK:  n_state = escape ? S_OUT : S_DBL;
            S_DBL:  if (i_mul_done) n_state = S_UPD;
            S_UPD:  n_state = (r_left == IB'(1)) ? S_OUT : S_SQX;
            S_OUT:  if (i_res_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_mul_done) begin
                r_issued <= 1'b0;
            end else if (o_mul_req.start) begin
                r_issued <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_px   <= i_pix.pixel_x;
                    r_py   <= i_pix.pixel_y;
                    r_left <= i_cfg.max_iterations;
                    r_zx   <= '0;
                    r_zy   <= '0;
                end
            end
            S_MAPX: if (i_mul_done) r_cx <= i_mul_res;
            S_MAPY: if (i_mul_done) r_cy <= i_mul_res;
            S_SQX:  if (i_mul_done) r_xx <= i_mul_res;
            S_SQY:  if (i_mul_done) r_yy <= i_mul_res;
            S_UPD: begin
                r_zx   <= sat_qz(upd_x);
                r_zy   <= sat_qz(upd_y);
                r_left <= r_left - IB'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall             = (r_state != S_IDLE);
    assign o_res_valid            = (r_state == S_OUT);
    assign o_res.out_x            = r_px;
    assign o_res.out_y            = r_py;
    assign o_res.remaining_budget = r_left;

`ifndef SYNTHESIS
    // The multiplier only reports back to a state that issued a request
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mul_done |-> (r_issued && in_mul_state))
        else $error("multiplier done without an outstanding request");

    // The budget only counts down while a pixel is in flight
    a_budget_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && $past(r_state) != S_IDLE) |-> (r_left <= $past(r_left)))
        else $error("iteration budget went up during a pixel");

    // A result leaves only on escape or with the budget spent
    a_out_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_left == '0 || escape))
        else $error("result issued without escape or budget exhaustion");
`endif

endmodule

[src/mandelbrot_escape_time_pixel.sv]
// Top level of the escape-time pixel evaluator: config, sequencer, multiplier, output register.
//
// Usage: a pixel request (column, row) enters on i_in_valid/i_pix and is taken
// at an edge where o_in_stall is low. The block maps it to a complex point c,
// iterates z = z*z + c in signed fixed point and returns the row, column and
// the iterations left when |z|^2 reached 4 or the budget ran out.
// All products go through one shared multiplier, which captures its operands,
// multiplies by the upper and then the lower half of one operand, and rescales
// and saturates. Mapping takes two products; every full iteration takes three
// products, the escape test and the update, and the escaping iteration two
// products and the escape test. One pixel is in work at a time; o_in_stall
// stays high from the request until the result moves into the output register.
// The output register holds a result while i_out_stall is high; the sequencer
// waits meanwhile. Configuration writes are taken every cycle on the i_cfg_*
// channel and must only be issued while no pixel is in work.
// Reset (i_rst_n low, synchronous) restores the register defaults, drops any
// pixel in work and empties the output register.
module mandelbrot_escape_time_pixel #(
    parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mbet_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [mbet_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  mbet_pkg::t_pix_in                   i_pix,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output mbet_pkg::t_pix_out                  o_out
);

    localparam int QW = mbet_pkg::qz_w(FRAC_BITS);
    localparam int SW = mbet_pkg::op_w(FRAC_BITS);

    mbet_pkg::t_cfg       cfg;
    mbet_pkg::t_mul_req   mul_req;
    logic signed [SW-1:0] mul_a;
    logic signed [SW-1:0] mul_b;
    logic                 mul_done;
    logic signed [QW-1:0] mul_res;
    logic                 res_valid;
    mbet_pkg::t_pix_out   res;
    logic                 res_take;

    logic                 r_out_valid;
    mbet_pkg::t_pix_out   r_out;

    mbet_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mbet_seq #(
        .FRAC_BITS (FRAC_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .i_pix       (i_pix),
        .o_in_stall  (o_in_stall),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_mul_req   (mul_req),
        .o_mul_a     (mul_a),
        .o_mul_b     (mul_b),
        .i_mul_done  (mul_done),
        .i_mul_res   (mul_res)
    );

    mbet_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // Output register takes a result when empty or draining this cycle
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
